FILE: sv/grid_astar_next_step_unit_defines.svh
// Assertion macros for the grid path search top level.
`ifndef GRID_ASTAR_NEXT_STEP_UNIT_DEFINES_SVH
`define GRID_ASTAR_NEXT_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GASN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gasn assertion failed");

// Next-cycle implication.
`define GASN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gasn assertion failed");

`endif

FILE: sv/gasn_pkg.sv
// Types, constants and helpers for the grid path search unit.
`timescale 1ns / 1ps
package gasn_pkg;

  localparam int GRID_SIDE  = 64;
  localparam int COORD_W    = 6;
  localparam int CELL_W     = 12;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int OPEN_DEPTH = 4096;
  localparam int QADDR_W    = 12;
  localparam int CNT_W      = 13;
  localparam int COST_W     = 16;
  localparam int DIM_W      = 7;
  localparam int LIMIT_W    = 9;

  localparam logic [COST_W-1:0] COST_STRAIGHT = 16'd10;
  localparam logic [COST_W-1:0] COST_DIAG     = 16'd14;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic              seen;
    logic [COST_W-1:0] g;
    logic [CELL_W-1:0] parent;
  } node_t;

  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] f;
    logic [CELL_W-1:0] key;
  } q_entry_t;

  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] key;
  } pop_rsp_t;

  // neighbour offsets, two-bit signed
  function automatic logic signed [1:0] step_dx(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd0, 3'd4, 3'd5: r = 2'sd1;
      3'd1, 3'd6, 3'd7: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd2, 3'd4, 3'd6: r = 2'sd1;
      3'd3, 3'd5, 3'd7: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] manhattan(input logic [CELL_W-1:0] c,
                                                 input logic [CELL_W-1:0] t);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (c[5:0] > t[5:0]) ? c[5:0] - t[5:0] : t[5:0] - c[5:0];
    dy = (c[11:6] > t[11:6]) ? c[11:6] - t[11:6] : t[11:6] - c[11:6];
    return {1'b0, dx} + {1'b0, dy};
  endfunction

endpackage

FILE: sv/grid_astar_next_step_unit.sv
// Top level: occupancy map, node store and the search sequencer.
//
//  channel  dir  handshake                     word
//  command  in   start / busy                  cmd, cell, blocked, start, target
//  config   in   cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//  result   out  result_valid_o (1 cycle)      next_x/y, moved, reached
//
// A cell write is taken while idle and busy stays low. A step command that
// starts a search holds busy for a clear pass of the node store, then per
// pop one scan of the open list (each entry pushed so far, up to 8*limit-7),
// an issue state per neighbour and an evaluate state per in-grid neighbour,
// then a read and a check per trace hop. The two-port node store and the
// open-list scan set the rate. Reset is asynchronous; after reset busy stays
// high for a pass that clears the occupancy map. The node store is cleared
// per search. Results are a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`include "grid_astar_next_step_unit_defines.svh"
module grid_astar_next_step_unit import gasn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [COORD_W-1:0] cell_x_i,
  input  logic [COORD_W-1:0] cell_y_i,
  input  logic               blocked_i,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0] target_x_i,
  input  logic [COORD_W-1:0] target_y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [COORD_W-1:0] next_x_o,
  output logic [COORD_W-1:0] next_y_o,
  output logic               moved_o,
  output logic               reached_o
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_CLEAR    = 12'b000000000010,
    ST_INIT     = 12'b000000000100,
    ST_POP_CHK  = 12'b000000001000,
    ST_POP_WAIT = 12'b000000010000,
    ST_G_WAIT   = 12'b000000100000,
    ST_NB_ISSUE = 12'b000001000000,
    ST_NB_EVAL  = 12'b000010000000,
    ST_TR_RD    = 12'b000100000000,
    ST_TR_EV    = 12'b001000000000,
    ST_DONE     = 12'b010000000000,
    ST_WIPE     = 12'b100000000000
  } state_e;

  // ---- configuration registers ----
  logic [DIM_W-1:0]   width_q, height_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(GRID_SIDE);
      height_q <= DIM_W'(GRID_SIDE);
      limit_q  <= 9'd400;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- state ----
  state_e             state_q, state_d;
  logic [DIM_W-1:0]   w_q, w_d, h_q, h_d;
  logic [LIMIT_W-1:0] lim_q, lim_d, pops_q, pops_d;
  logic [CELL_W-1:0]  skey_q, skey_d, tkey_q, tkey_d;
  logic [CELL_W-1:0]  cur_q, cur_d, best_q, best_d, nkey_q, nkey_d;
  logic [DIM_W-1:0]   bestd_q, bestd_d;
  logic               hit_q, hit_d;
  logic [COST_W-1:0]  gcur_q, gcur_d;
  logic [2:0]         k_q, k_d;
  logic [CELL_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0]   guard_q, guard_d;
  logic [CELL_W-1:0]  step_q, step_d;
  logic [COORD_W-1:0] nx_q, nx_d, ny_q, ny_d;
  logic               mv_q, mv_d, rch_q, rch_d;

  // ---- memories ----
  logic  occ_mem [CELL_COUNT];
  node_t node_mem [CELL_COUNT];
  logic  occ_rd_q;
  node_t node_rd_q;

  logic              occ_we;
  logic              occ_wd;
  logic [CELL_W-1:0] occ_wa, occ_ra;
  logic              node_we;
  logic [CELL_W-1:0] node_wa, node_ra;
  node_t             node_wd;

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_rd_q <= occ_mem[occ_ra];
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_rd_q <= node_mem[node_ra];
  end

  // ---- open list ----
  logic              q_clr, q_push, q_pop, q_empty;
  logic [COST_W-1:0] q_f;
  pop_rsp_t          q_rsp;

  gasn_open_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (q_clr),
    .push_i      (q_push),
    .push_f_i    (q_f),
    .push_cell_i (nkey_q),
    .pop_i       (q_pop),
    .rsp_o       (q_rsp),
    .empty_o     (q_empty)
  );

  // ---- neighbour arithmetic ----
  logic signed [1:0] off_x, off_y;
  logic [7:0]        nb_x, nb_y;
  logic              nb_out;
  logic [COST_W-1:0] g_new;
  logic [DIM_W-1:0]  h_cur;
  logic              accept;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    off_x  = step_dx(k_q);
    off_y  = step_dy(k_q);
    nb_x   = {2'b00, cur_q[5:0]} + {{6{off_x[1]}}, off_x};
    nb_y   = {2'b00, cur_q[11:6]} + {{6{off_y[1]}}, off_y};
    nb_out = nb_x[7] || nb_y[7] || (nb_x[6:0] >= w_q) || (nb_y[6:0] >= h_q);
    g_new  = gcur_q + (k_q[2] ? COST_DIAG : COST_STRAIGHT);
    h_cur  = manhattan(q_rsp.key, tkey_q);
    q_f    = g_new + COST_W'(manhattan(nkey_q, tkey_q));
  end

  always_comb begin
    state_d = state_q;
    w_d = w_q;        h_d = h_q;        lim_d = lim_q;
    skey_d = skey_q;  tkey_d = tkey_q;  cur_d = cur_q;
    best_d = best_q;  bestd_d = bestd_q; hit_d = hit_q;
    gcur_d = gcur_q;  k_d = k_q;        nkey_d = nkey_q;
    pops_d = pops_q;  clr_d = clr_q;    guard_d = guard_q;
    step_d = step_q;
    nx_d = nx_q; ny_d = ny_q; mv_d = mv_q; rch_d = rch_q;
    occ_we = 1'b0;
    occ_wd = blocked_i;
    occ_wa = {cell_y_i, cell_x_i};
    occ_ra = nb_y[5:0] == 6'd0 ? {6'd0, nb_x[5:0]} : {nb_y[5:0], nb_x[5:0]};
    node_we = 1'b0;
    node_wa = clr_q;
    node_wd = '0;
    node_ra = cur_q;
    q_clr = 1'b0;
    q_push = 1'b0;
    q_pop = 1'b0;
    case (state_q)
      ST_WIPE: begin
        // every cell starts free
        occ_we = 1'b1;
        occ_wd = 1'b0;
        occ_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_WRITE) begin
            occ_we = 1'b1;
          end else begin
            w_d    = (width_q > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : width_q;
            h_d    = (height_q > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : height_q;
            lim_d  = limit_q;
            skey_d = {start_y_i, start_x_i};
            tkey_d = {target_y_i, target_x_i};
            nx_d = start_x_i; ny_d = start_y_i; mv_d = 1'b0; rch_d = 1'b0;
            hit_d = 1'b0;
            clr_d = '0;
            if (start_x_i == target_x_i && start_y_i == target_y_i) begin
              rch_d   = 1'b1;
              state_d = ST_DONE;
            end else if ({1'b0, start_x_i} >= w_d || {1'b0, start_y_i} >= h_d) begin
              state_d = ST_DONE;
            end else begin
              q_clr   = 1'b1;
              state_d = ST_CLEAR;
            end
          end
        end
      end
      ST_CLEAR: begin
        node_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        node_we = 1'b1;
        node_wa = skey_q;
        node_wd.seen = 1'b1;
        nkey_d  = skey_q;
        best_d  = skey_q;
        bestd_d = manhattan(skey_q, tkey_q);
        hit_d   = 1'b0;
        pops_d  = '0;
        gcur_d  = '0;
        k_d     = 3'd0;
        state_d = ST_NB_EVAL;   // reuse push path with a forced entry
      end
      ST_POP_CHK: begin
        if (!q_empty && pops_q < lim_q) begin
          q_pop   = 1'b1;
          state_d = ST_POP_WAIT;
        end else begin
          state_d = ST_TR_RD;
          step_d  = best_q;
          guard_d = '0;
          if (best_q == skey_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_POP_WAIT: begin
        if (q_rsp.done) begin
          cur_d  = q_rsp.key;
          pops_d = pops_q + 1'b1;
          if (q_rsp.key == tkey_q) begin
            best_d  = q_rsp.key;
            hit_d   = 1'b1;
            step_d  = q_rsp.key;
            guard_d = '0;
            rch_d   = 1'b1;
            state_d = ST_TR_RD;
          end else begin
            if (h_cur < bestd_q) begin
              bestd_d = h_cur;
              best_d  = q_rsp.key;
            end
            node_ra = q_rsp.key;
            state_d = ST_G_WAIT;
          end
        end
      end
      ST_G_WAIT: begin
        gcur_d  = node_rd_q.g;
        k_d     = 3'd0;
        state_d = ST_NB_ISSUE;
      end
      ST_NB_ISSUE: begin
        occ_ra  = {nb_y[5:0], nb_x[5:0]};
        node_ra = {nb_y[5:0], nb_x[5:0]};
        nkey_d  = {nb_y[5:0], nb_x[5:0]};
        if (nb_out) begin
          k_d = k_q + 1'b1;
          if (k_q == 3'd7) begin
            state_d = ST_POP_CHK;
          end
        end else begin
          state_d = ST_NB_EVAL;
        end
      end
      ST_NB_EVAL: begin
        if (pops_q == '0) begin
          // start entry: the only one in the list, so its f order is moot
          q_push  = 1'b1;
          state_d = ST_POP_CHK;
        end else begin
          if ((!occ_rd_q || nkey_q == tkey_q) &&
              (!node_rd_q.seen || g_new < node_rd_q.g)) begin
            node_we = 1'b1;
            node_wa = nkey_q;
            node_wd.seen   = 1'b1;
            node_wd.g      = g_new;
            node_wd.parent = cur_q;
            q_push = 1'b1;
          end
          k_d = k_q + 1'b1;
          state_d = (k_q == 3'd7) ? ST_POP_CHK : ST_NB_ISSUE;
        end
      end
      ST_TR_RD: begin
        node_ra = step_q;
        state_d = ST_TR_EV;
        if (step_q == skey_q) begin
          // only when nothing moved: handled in ST_POP_CHK
          state_d = ST_DONE;
        end
      end
      ST_TR_EV: begin
        if (node_rd_q.parent == skey_q || guard_q >= CNT_W'(CELL_COUNT)) begin
          nx_d = step_q[5:0];
          ny_d = step_q[11:6];
          mv_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          step_d  = node_rd_q.parent;
          guard_d = guard_q + 1'b1;
          state_d = ST_TR_RD;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIPE;
      pops_q  <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      guard_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pops_q  <= pops_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      guard_q <= guard_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;       h_q <= h_d;       lim_q <= lim_d;
    skey_q <= skey_d; tkey_q <= tkey_d; cur_q <= cur_d;
    best_q <= best_d; bestd_q <= bestd_d;
    gcur_q <= gcur_d; nkey_q <= nkey_d; step_q <= step_d;
    nx_q <= nx_d; ny_q <= ny_d; mv_q <= mv_d; rch_q <= rch_d;
  end

  assign result_valid_o = (state_q == ST_DONE);
  assign next_x_o       = nx_q;
  assign next_y_o       = ny_q;
  assign moved_o        = mv_q;
  assign reached_o      = rch_q;

  // ---- checks ----
  `GASN_ASSERT_NXT(a_strobe_single, result_valid_o, !result_valid_o)
  `GASN_ASSERT_NXT(a_step_goes_busy, accept && cmd_i == CMD_STEP, busy)
  `GASN_ASSERT_IMP(a_moved_differs, result_valid_o && moved_o,
                   {next_y_o, next_x_o} != skey_q)
  `GASN_ASSERT_IMP(a_hit_reached, result_valid_o && hit_q, reached_o)

endmodule

FILE: sv/gasn_open_queue.sv
// Open list: push-ordered entry memory with a min-f scan and pop.
`timescale 1ns / 1ps
module gasn_open_queue import gasn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              push_i,
  input  logic [COST_W-1:0] push_f_i,
  input  logic [CELL_W-1:0] push_cell_i,
  input  logic              pop_i,
  output pop_rsp_t          rsp_o,
  output logic              empty_o
);

  typedef enum logic [2:0] {
    Q_IDLE = 3'b001,
    Q_SCAN = 3'b010,
    Q_TAKE = 3'b100
  } q_state_e;

  q_entry_t mem [OPEN_DEPTH];

  q_state_e          state_q, state_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [QADDR_W-1:0] rd_idx_q;
  logic              rd_vld_q, rd_vld_d;
  q_entry_t          rd_q;
  logic              found_q, found_d;
  logic [COST_W-1:0] bf_q, bf_d;
  logic [QADDR_W-1:0] bidx_q, bidx_d;
  logic [CELL_W-1:0] bcell_q, bcell_d;
  logic              push_ok, take;
  logic              we;
  logic [QADDR_W-1:0] wa;
  q_entry_t          wd;

  assign push_ok = push_i && (tail_q < CNT_W'(OPEN_DEPTH));
  assign take    = (state_q == Q_TAKE);
  assign empty_o = (count_q == '0);
  assign rsp_o.done = take;
  assign rsp_o.key  = bcell_q;

  always_comb begin
    we = take || push_ok;
    wa = take ? bidx_q : tail_q[QADDR_W-1:0];
    wd.valid = !take;
    wd.f     = push_f_i;
    wd.key   = push_cell_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q     <= mem[idx_q[QADDR_W-1:0]];
    rd_idx_q <= idx_q[QADDR_W-1:0];
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    found_d  = found_q;
    bf_d     = bf_q;
    bidx_d   = bidx_q;
    bcell_d  = bcell_q;
    tail_d   = clr_i ? '0 : tail_q + CNT_W'(push_ok);
    count_d  = clr_i ? '0 : count_q + CNT_W'(push_ok) - CNT_W'(take);
    case (state_q)
      Q_IDLE: begin
        if (pop_i) begin
          state_d = Q_SCAN;
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      Q_SCAN: begin
        if (idx_q < tail_q) begin
          rd_vld_d = 1'b1;
          idx_d    = idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = Q_TAKE;
        end
        // strict less keeps the earliest push among equal f
        if (rd_vld_q && rd_q.valid && (!found_q || rd_q.f < bf_q)) begin
          found_d = 1'b1;
          bf_d    = rd_q.f;
          bidx_d  = rd_idx_q;
          bcell_d = rd_q.key;
        end
      end
      Q_TAKE: begin
        state_d = Q_IDLE;
      end
      default: state_d = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= Q_IDLE;
      tail_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bf_q    <= bf_d;
    bidx_q  <= bidx_d;
    bcell_q <= bcell_d;
  end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the grid A* next-step unit.
`timescale 1ns / 1ps
module tb_top;
  import gasn_pkg::*;

  // No-progress limit. The worst single step at a 64x64 grid with a 400-pop
  // budget scans at most about 0.64M open-list entries; allow several times that.
  localparam int WATCHDOG_LIMIT = 6_000_000;

  typedef struct {
    logic               cmd;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               blk;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
  } cmd_word_t;

  typedef struct {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic               moved;
    logic               reached;
  } step_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cmd_i = CMD_WRITE;
  logic [COORD_W-1:0] cell_x_i = '0;
  logic [COORD_W-1:0] cell_y_i = '0;
  logic blocked_i = 1'b0;
  logic [COORD_W-1:0] start_x_i = '0;
  logic [COORD_W-1:0] start_y_i = '0;
  logic [COORD_W-1:0] target_x_i = '0;
  logic [COORD_W-1:0] target_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_WIDTH;
  logic [8:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [COORD_W-1:0] next_x_o;
  logic [COORD_W-1:0] next_y_o;
  logic moved_o;
  logic reached_o;

  always #2 clk_i = ~clk_i;

  grid_astar_next_step_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .cell_x_i(cell_x_i), .cell_y_i(cell_y_i), .blocked_i(blocked_i),
    .start_x_i(start_x_i), .start_y_i(start_y_i),
    .target_x_i(target_x_i), .target_y_i(target_y_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o), .next_x_o(next_x_o), .next_y_o(next_y_o),
    .moved_o(moved_o), .reached_o(reached_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers, occupancy map and search scratch
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   sh_width = 7'd64;
  logic [DIM_W-1:0]   sh_height = 7'd64;
  logic [LIMIT_W-1:0] sh_limit = 9'd400;
  bit  occ_map [CELL_COUNT];
  bit  visited [CELL_COUNT];
  int  g_cost [CELL_COUNT];
  int  parent_of [CELL_COUNT];
  int  open_f [OPEN_DEPTH];
  int  open_cell [OPEN_DEPTH];
  int  open_n;

  cmd_word_t  pending_cmds[$];   // words waiting for the driver
  step_word_t expected_steps[$]; // predicted next-step words, oldest first
  int errors = 0;
  bit dense = 1'b0;              // phase-wide: no gaps on the command side

  task report(input string what, input int got, input int want);
    $display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function int hdist(input int x, input int y, input int tx, input int ty);
    return (x > tx ? x - tx : tx - x) + (y > ty ? y - ty : ty - y);
  endfunction

  function void open_push(input int f, input int c);
    if (open_n >= OPEN_DEPTH) return;  // full list drops the push
    open_f[open_n] = f;
    open_cell[open_n] = c;
    open_n++;
  endfunction

  // min f, oldest entry wins a tie
  function int open_pop();
    int bi;
    int c;
    bi = 0;
    for (int i = 1; i < open_n; i++)
      if (open_f[i] < open_f[bi]) bi = i;
    c = open_cell[bi];
    for (int i = bi; i < open_n - 1; i++) begin
      open_f[i] = open_f[i+1];
      open_cell[i] = open_cell[i+1];
    end
    open_n--;
    return c;
  endfunction

  // Apply one accepted command word to the shadow; for a step, queue the answer.
  function void predict_step(input cmd_word_t wd);
    int w, h, sx, sy, tx, ty, sk, best, bestd, pops, cur, cx, cy, d;
    int nx, ny, nk, g, hop, guard;
    bit hit;
    step_word_t r;
    if (wd.cmd == CMD_WRITE) begin
      occ_map[wd.cy * GRID_SIDE + wd.cx] = wd.blk;
      return;
    end
    sx = wd.sx; sy = wd.sy; tx = wd.tx; ty = wd.ty;
    w = (sh_width > GRID_SIDE) ? GRID_SIDE : sh_width;
    h = (sh_height > GRID_SIDE) ? GRID_SIDE : sh_height;
    r.nx = wd.sx; r.ny = wd.sy; r.moved = 1'b0; r.reached = 1'b0;
    hit = 1'b0;
    if (sx == tx && sy == ty) begin
      r.reached = 1'b1;
      expected_steps.push_back(r);
      return;
    end
    if (sx >= w || sy >= h) begin
      expected_steps.push_back(r);
      return;
    end
    foreach (visited[i]) visited[i] = 1'b0;
    open_n = 0;
    sk = sy * GRID_SIDE + sx;
    visited[sk] = 1'b1;
    g_cost[sk] = 0;
    bestd = hdist(sx, sy, tx, ty);
    open_push(bestd, sk);
    best = sk;
    pops = 0;
    while (open_n > 0 && pops < sh_limit) begin
      cur = open_pop();
      cx = cur % GRID_SIDE;
      cy = cur / GRID_SIDE;
      pops++;
      if (cx == tx && cy == ty) begin
        best = cur;
        hit = 1'b1;
        break;
      end
      d = hdist(cx, cy, tx, ty);
      if (d < bestd) begin
        bestd = d;
        best = cur;
      end
      for (int k = 0; k < 8; k++) begin
        // neighbour order: E W S N, then SE NE SW NW
        case (k)
          0: begin nx = cx + 1; ny = cy;     end
          1: begin nx = cx - 1; ny = cy;     end
          2: begin nx = cx;     ny = cy + 1; end
          3: begin nx = cx;     ny = cy - 1; end
          4: begin nx = cx + 1; ny = cy + 1; end
          5: begin nx = cx + 1; ny = cy - 1; end
          6: begin nx = cx - 1; ny = cy + 1; end
          default: begin nx = cx - 1; ny = cy - 1; end
        endcase
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        nk = ny * GRID_SIDE + nx;
        // target is enterable even when marked occupied
        if (occ_map[nk] && !(nx == tx && ny == ty)) continue;
        g = g_cost[cur] + ((k < 4) ? int'(COST_STRAIGHT) : int'(COST_DIAG));
        if (!visited[nk] || g < g_cost[nk]) begin
          visited[nk] = 1'b1;
          parent_of[nk] = cur;
          g_cost[nk] = g;
          open_push(g + hdist(nx, ny, tx, ty), nk);
        end
      end
    end
    if (best != sk) begin
      hop = best;
      guard = 0;
      while (parent_of[hop] != sk && guard < CELL_COUNT) begin
        hop = parent_of[hop] % CELL_COUNT;
        guard++;
      end
      r.nx = COORD_W'(hop % GRID_SIDE);
      r.ny = COORD_W'(hop / GRID_SIDE);
      r.moved = 1'b1;
    end
    r.reached = hit;
    expected_steps.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: one word per start/!busy edge; unless dense, random gaps between words
  // ---------------------------------------------------------------------------
  cmd_word_t cur_word;
  int gap_left = 0;
  int pick;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_step(cur_word);
        pick = $urandom_range(0, 99);
        if (dense || pick < 50) gap_left = 0;
        else if (pick < 92) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(10, 60);
      end
      if (start && busy) begin
        // hold the word until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_word = pending_cmds.pop_front();
        cmd_i <= cur_word.cmd;
        cell_x_i <= cur_word.cx;
        cell_y_i <= cur_word.cy;
        blocked_i <= cur_word.blk;
        start_x_i <= cur_word.sx;
        start_y_i <= cur_word.sy;
        target_x_i <= cur_word.tx;
        target_y_i <= cur_word.ty;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: strobed words checked against the oldest prediction
  // ---------------------------------------------------------------------------
  step_word_t want;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_steps.size() == 0) begin
        report("unexpected result, next_x", int'(next_x_o), -1);
      end else begin
        want = expected_steps.pop_front();
        if (next_x_o !== want.nx) report("next_x", int'(next_x_o), int'(want.nx));
        if (next_y_o !== want.ny) report("next_y", int'(next_y_o), int'(want.ny));
        if (moved_o !== want.moved) report("moved", int'(moved_o), int'(want.moved));
        if (reached_o !== want.reached)
          report("reached", int'(reached_o), int'(want.reached));
      end
    end
  end

  // watchdog on handshake progress
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: timeout, no handshake progress");
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task cfg_write(input logic [1:0] idx, input logic [8:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH:  sh_width = data[DIM_W-1:0];
      CFG_HEIGHT: sh_height = data[DIM_W-1:0];
      CFG_LIMIT:  sh_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every word is taken and answered, then let a cell write settle
  task drain();
    do @(posedge clk_i);
    while (pending_cmds.size() > 0 || start || expected_steps.size() > 0 || busy);
    repeat (10) @(posedge clk_i);
  endtask

  function cmd_word_t wr_word(input int x, input int y, input bit b);
    cmd_word_t c;
    c = '{CMD_WRITE, COORD_W'(x), COORD_W'(y), b, COORD_W'($urandom),
          COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
    return c;
  endfunction

  function cmd_word_t st_word(input int sx, input int sy, input int tx, input int ty);
    cmd_word_t c;
    c = '{CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom),
          COORD_W'(sx), COORD_W'(sy), COORD_W'(tx), COORD_W'(ty)};
    return c;
  endfunction

  function int coord_in(input int span);
    if (span < 1 || $urandom_range(0, 99) < 10) return $urandom_range(0, 63);
    return $urandom_range(0, span - 1);
  endfunction

  // Random mix of cell writes and steps, mostly in a span_w x span_h window.
  // near > 0 keeps targets within that distance of the start.
  task queue_random(input int n, input int span_w, input int span_h, input int near);
    int sx, sy, tx, ty;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        pending_cmds.push_back(wr_word(coord_in(span_w), coord_in(span_h),
                                       $urandom_range(0, 99) < 35));
      end else begin
        sx = coord_in(span_w);
        sy = coord_in(span_h);
        if (near > 0) begin
          tx = sx + $urandom_range(0, 2 * near) - near;
          ty = sy + $urandom_range(0, 2 * near) - near;
          tx = tx < 0 ? 0 : (tx > 63 ? 63 : tx);
          ty = ty < 0 ? 0 : (ty > 63 ? 63 : ty);
        end else begin
          tx = coord_in(span_w);
          ty = coord_in(span_h);
        end
        pending_cmds.push_back(st_word(sx, sy, tx, ty));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config 64x64 / 400 pops
    dense = 1'b1;
    pending_cmds.push_back(wr_word(63, 63, 1));
    pending_cmds.push_back(wr_word(0, 0, 1));
    pending_cmds.push_back(wr_word(0, 0, 0));
    pending_cmds.push_back(st_word(5, 5, 5, 5));      // start equals target
    pending_cmds.push_back(st_word(60, 60, 63, 63));  // occupied target still entered
    pending_cmds.push_back(wr_word(11, 9, 1));
    pending_cmds.push_back(wr_word(11, 10, 1));
    pending_cmds.push_back(wr_word(11, 11, 1));
    pending_cmds.push_back(st_word(10, 10, 12, 10));  // detour round a wall
    pending_cmds.push_back(st_word(0, 0, 1, 1));      // diagonal neighbour
    pending_cmds.push_back(st_word(63, 0, 55, 4));
    drain();

    // oversize width clamps to the grid side, zero height leaves no cell in use
    dense = 1'b0;
    cfg_write(CFG_WIDTH, 9'h1FF);
    cfg_write(CFG_HEIGHT, 9'd0);
    pending_cmds.push_back(st_word(3, 0, 7, 0));      // start outside the grid
    pending_cmds.push_back(st_word(4, 4, 4, 4));
    drain();

    // small square, roomy budget; target outside the grid never reached
    cfg_write(CFG_WIDTH, 9'd8);
    cfg_write(CFG_HEIGHT, 9'd8);
    cfg_write(CFG_LIMIT, 9'd400);
    pending_cmds.push_back(st_word(1, 1, 20, 2));
    pending_cmds.push_back(wr_word(70 % 64, 63, 1));
    drain();
    queue_random(45, 8, 8, 0);
    drain();

    // single column, one pop only
    cfg_write(CFG_WIDTH, 9'd1);
    cfg_write(CFG_HEIGHT, 9'd64);
    cfg_write(CFG_LIMIT, 9'd1);
    pending_cmds.push_back(st_word(0, 10, 0, 12));
    drain();
    queue_random(10, 1, 16, 0);
    drain();

    // zero budget: no pop, no move
    dense = 1'b1;
    cfg_write(CFG_WIDTH, 9'd16);
    cfg_write(CFG_HEIGHT, 9'd5);
    cfg_write(CFG_LIMIT, 9'd0);
    pending_cmds.push_back(st_word(2, 2, 9, 3));
    queue_random(8, 16, 5, 0);
    drain();

    // mid-size grid, a tight random budget
    dense = 1'b0;
    cfg_write(CFG_WIDTH, 9'd12);
    cfg_write(CFG_HEIGHT, 9'd12);
    cfg_write(CFG_LIMIT, 9'($urandom_range(2, 30)));
    queue_random(30, 12, 12, 0);
    drain();

    // full size, widest limit field, targets kept near the start
    cfg_write(CFG_WIDTH, 9'd64);
    cfg_write(CFG_HEIGHT, 9'd64);
    cfg_write(CFG_LIMIT, 9'h1FF);
    queue_random(20, 64, 64, 5);
    drain();

    // full size, a short budget so searches stop early
    cfg_write(CFG_LIMIT, 9'($urandom_range(1, 40)));
    queue_random(25, 64, 64, 0);
    drain();

    // expectations still waiting count as failures
    while (expected_steps.size() > 0) begin
      want = expected_steps.pop_front();
      report("missing result, next_x", -1, int'(want.nx));
    end
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/gasn_pkg.sv
sv/gasn_open_queue.sv
sv/grid_astar_next_step_unit.sv
verif/tb_top.sv
